>>> hw/rtl/cler_pkg.sv
// Package for the command line editor and recognizer.
// Types, action codes and command name table; no dependencies.
`default_nettype none
package cler_pkg;
  typedef enum logic [2:0] {
    ACT_IGNORE = 3'd0,
    ACT_ECHO   = 3'd1,
    ACT_BELL   = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_LINE   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERASE_RD,
    ST_ERASE_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;
  localparam int NUM_CMDS = 5;
  localparam int WORD_LIMIT = 4;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  // command name characters, position beyond length returns zero
  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [2:0] i);
    logic [39:0] s;
    case (k)
      3'd0: s = {24'h0, "1f"};
      3'd1: s = {8'h0, "llif"};
      3'd2: s = {8'h0, "pmud"};
      3'd3: s = "olleh";
      3'd4: s = {8'h0, "musx"};
      default: s = '0;
    endcase
    if (i > 3'd4) return 8'h00;
    return s[i*8 +: 8];
  endfunction

  function automatic logic [2:0] cmd_len(input logic [2:0] k);
    case (k)
      3'd0: return 3'd2;
      3'd3: return 3'd5;
      default: return 3'd4;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/command_line_editor_recognizer_top.sv
// Top level of the command line editor and recognizer.
// Uses cler_pkg and cler_ram.
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | rx_byte[7:0]
// m_axis  | out | action, echo_byte, word_count, command_found, command_index,
//         |     | word0..3_start, line_length (48 bits)
//
// Every transfer passes through idle and the result stage (ST_DONE), where the
// result is registered and m_axis_tvalid is set. Erase adds a RAM read state
// and a check state per byte removed, as the RAM read is registered. A newline
// adds a read and a check state per stored byte scanned, at most LINE_CAPACITY-1
// bytes. One item is in work at a time and the input stalls while a result waits.
// rst clears the count and control state; the line RAM is not cleared.
`default_nettype none
module command_line_editor_recognizer_top #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata    // action, echo_byte, word_count,
                                           // command_found, command_index,
                                           // word0..3_start, line_length
);
  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  cler_pkg::state_t state, state_next;
  logic [CW-1:0] count, ptr, len;
  logic [7:0]  rx;
  logic [2:0]  nw;
  logic        in_word, first_open;
  logic [CW-1:0] starts [4];
  logic [2:0]  mpos;
  logic [4:0]  cand;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  rdata;
  logic        accept, out_busy;

  cler_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(s_axis_tdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (state == cler_pkg::ST_IDLE) && !out_busy;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign waddr = count[AW-1:0];
  assign we = accept && s_axis_tdata >= cler_pkg::CH_SPACE
              && s_axis_tdata != cler_pkg::CH_DEL
              && count < CW'(LINE_CAPACITY - 1);
  assign raddr = ptr[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      cler_pkg::ST_IDLE:
        if (accept) begin
          if (s_axis_tdata == cler_pkg::CH_LF)
            state_next = (count == '0) ? cler_pkg::ST_DONE : cler_pkg::ST_SCAN_RD;
          else if ((s_axis_tdata == cler_pkg::CH_BS || s_axis_tdata == cler_pkg::CH_DEL)
                   && count != '0)
            state_next = cler_pkg::ST_ERASE_RD;
          else state_next = cler_pkg::ST_DONE;
        end
      cler_pkg::ST_ERASE_RD: state_next = cler_pkg::ST_ERASE_CHK;
      cler_pkg::ST_ERASE_CHK:
        state_next = (count != '0 && (rdata & cler_pkg::CONT_MASK) == cler_pkg::CONT_CODE)
                     ? cler_pkg::ST_ERASE_RD : cler_pkg::ST_DONE;
      cler_pkg::ST_SCAN_RD: state_next = cler_pkg::ST_SCAN_CHK;
      cler_pkg::ST_SCAN_CHK:
        state_next = (ptr + 1'b1 >= len ||
                      (rdata > cler_pkg::CH_SPACE && !in_word && nw == 3'd4))
                     ? cler_pkg::ST_DONE : cler_pkg::ST_SCAN_RD;
      cler_pkg::ST_DONE: state_next = cler_pkg::ST_IDLE;
      default: state_next = cler_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cler_pkg::ST_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state == cler_pkg::ST_DONE) m_axis_tvalid <= 1'b1;
      if (accept) begin
        if (s_axis_tdata == cler_pkg::CH_LF) count <= '0;
        else if ((s_axis_tdata == cler_pkg::CH_BS || s_axis_tdata == cler_pkg::CH_DEL)
                 && count != '0) count <= count - 1'b1;
        else if (we) count <= count + 1'b1;
      end
      if (state == cler_pkg::ST_ERASE_CHK && state_next == cler_pkg::ST_ERASE_RD)
        count <= count - 1'b1;
    end
  end

  // erase: ptr tracks count; scan: ptr walks 0..len-1
  logic [7:0] fc;
  logic [2:0] k;
  always_comb begin
    fc = cler_pkg::fold_case(rdata);
    for (int i = 0; i < cler_pkg::NUM_CMDS; i++) begin
      k = 3'(i);
      cand[i] = 1'b0;
      if (mpos < cler_pkg::cmd_len(k)) cand[i] = (fc == cler_pkg::cmd_char(k, mpos));
    end
  end

  logic [4:0] alive;
  always_ff @(posedge clk) begin
    if (accept) begin
      rx <= s_axis_tdata;
      len <= count;
      ptr <= (s_axis_tdata == cler_pkg::CH_LF) ? '0 : count - 1'b1;
      nw <= '0;
      in_word <= 1'b0;
      first_open <= 1'b0;
      alive <= '1;
      mpos <= '0;
      for (int i = 0; i < 4; i++) starts[i] <= '0;
    end
    if (state == cler_pkg::ST_ERASE_CHK) ptr <= ptr - 1'b1;
    if (state == cler_pkg::ST_SCAN_CHK) begin
      ptr <= ptr + 1'b1;
      if (rdata <= cler_pkg::CH_SPACE) begin
        if (first_open) begin
          first_open <= 1'b0;
          for (int i = 0; i < 5; i++)
            if (mpos != cler_pkg::cmd_len(3'(i))) alive[i] <= 1'b0;
        end
        in_word <= 1'b0;
      end else if (!in_word) begin
        if (nw != 3'd4) begin
          starts[nw[1:0]] <= ptr;
          nw <= nw + 1'b1;
          in_word <= 1'b1;
          if (nw == 3'd0) begin
            first_open <= 1'b1;
            alive <= alive & cand;
            mpos <= 3'd1;
          end
        end
      end else if (first_open) begin
        alive <= alive & cand;
        if (mpos != 3'd7) mpos <= mpos + 1'b1;
      end
    end
  end

  // final match: first word still open at end means length must equal mpos
  logic [4:0] fin;
  logic       found;
  logic [2:0] idx;
  always_comb begin
    for (int i = 0; i < cler_pkg::NUM_CMDS; i++)
      fin[i] = alive[i] && (!first_open || mpos == cler_pkg::cmd_len(3'(i)));
    found = (nw != 3'd0) && (fin != '0);
    idx = '0;
    for (int i = 4; i >= 0; i--) if (fin[i]) idx = 3'(i);
    if (!found) idx = '0;
  end

  logic [2:0] act;
  always_comb begin
    act = cler_pkg::ACT_IGNORE;
    if (rx == cler_pkg::CH_LF) act = cler_pkg::ACT_LINE;
    else if (rx == cler_pkg::CH_BS || rx == cler_pkg::CH_DEL)
      act = (len == '0) ? cler_pkg::ACT_BELL : cler_pkg::ACT_ERASE;
    else if (rx >= cler_pkg::CH_SPACE)
      act = (len >= CW'(LINE_CAPACITY - 1)) ? cler_pkg::ACT_BELL : cler_pkg::ACT_ECHO;
  end

  logic [47:0] result;
  always_comb begin
    result = '0;
    result[2:0] = act;
    if (act == cler_pkg::ACT_ECHO) result[10:3] = rx;
    if (act == cler_pkg::ACT_LINE) begin
      result[13:11] = nw;
      result[14]    = found;
      result[17:15] = idx;
      result[23:18] = 6'(starts[0]);
      result[29:24] = 6'(starts[1]);
      result[35:30] = 6'(starts[2]);
      result[41:36] = 6'(starts[3]);
      result[47:42] = 6'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (state == cler_pkg::ST_DONE) m_axis_tdata <= result;
  end
endmodule
`default_nettype wire

>>> hw/rtl/cler_ram.sv
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
`default_nettype none
module cler_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/cler_checker.sv
// Port checker for the command line editor and recognizer.
// Bound to command_line_editor_recognizer_top; uses cler_pkg.
`default_nettype none
module cler_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= cler_pkg::ACT_LINE)
    else $error("bad action code");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer while busy");
  a_echo: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != cler_pkg::ACT_ECHO |-> m_axis_tdata[10:3] == 8'h00)
    else $error("echo byte on non-echo");
endmodule

bind command_line_editor_recognizer_top cler_checker u_cler_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
